// ----- sv/ddsr_pkg.sv -----
package ddsr_pkg;

  localparam int VEL_FRAC_BITS_DEF = 12;
  localparam int DEADBAND_DEF      = 4;
  localparam int QUEUE_DEPTH_DEF   = 4;

  localparam int VEL_W   = 16;
  localparam int FREQ_W  = 20;
  localparam int ACCEL_W = 15;
  localparam int GAIN_W  = 16;
  localparam int MODE_W  = 2;
  localparam int CFG_W   = 16;
  localparam int IDX_W   = 2;

  localparam logic [ACCEL_W-1:0] ACCEL_RESET = 15'd41;
  localparam logic [GAIN_W-1:0]  GAIN_RESET  = 16'd30476;

  typedef enum logic [IDX_W-1:0] {
    CFG_ACCEL = 2'd0,
    CFG_GAIN  = 2'd1,
    CFG_MODE  = 2'd2
  } cfg_index_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_CONTINUOUS = 2'd0,
    MODE_AUTO       = 2'd1,
    MODE_TURN360    = 2'd2
  } drive_mode_t;

  typedef enum logic [2:0] {
    KIND_CMD     = 3'd0,
    KIND_TICK    = 3'd1,
    KIND_TIMEOUT = 3'd2,
    KIND_EDGE    = 3'd3,
    KIND_SAMPLE  = 3'd4
  } kind_t;

  // Operation handed from the front to the back once an item is classified.
  typedef enum logic [2:0] {
    OP_NOP,
    OP_CMD,
    OP_TICK,
    OP_CLEAR,
    OP_EDGE,
    OP_SAMPLE
  } op_t;

  typedef struct packed {
    op_t                     op;
    logic signed [VEL_W-1:0] left_goal;
    logic signed [VEL_W-1:0] right_goal;
    logic                    left_edge;
    logic                    right_edge;
  } queue_entry_t;

  typedef struct packed {
    logic signed [VEL_W-1:0] left_speed;
    logic signed [VEL_W-1:0] right_speed;
    logic                    left_write;
    logic                    right_write;
    logic [VEL_W-1:0]        left_steps;
    logic [VEL_W-1:0]        right_steps;
  } ramp_rec_t;

endpackage

// ----- sv/ddsr_front.sv -----
module ddsr_front #(
  parameter int VEL_FRAC_BITS = ddsr_pkg::VEL_FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [ddsr_pkg::MODE_W-1:0]     drive_mode,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [2:0]                      kind,
  input  logic signed [15:0]              speed,
  input  logic signed [15:0]              turn,
  input  logic                            left_edge,
  input  logic                            right_edge,
  output logic                            q_push,
  input  logic                            q_ready,
  output ddsr_pkg::queue_entry_t          q_entry
);
  import ddsr_pkg::*;

  localparam int TURN_SHIFT = 14 - VEL_FRAC_BITS;
  localparam logic [16:0] TURN_BIAS = 17'((1 << TURN_SHIFT) - 1);

  // Quotient by 2^14 rounded toward zero, then saturated to 16 bits.
  function automatic logic signed [15:0] div_q14_sat(input logic signed [33:0] x);
    logic signed [33:0] b;
    b = x + (x[33] ? 34'sd16383 : 34'sd0);
    b = b >>> 14;
    if (b > 34'sd32767) begin
      return 16'sh7fff;
    end else if (b < -34'sd32768) begin
      return 16'sh8000;
    end else begin
      return b[15:0];
    end
  endfunction

  op_t                f1_op_in;
  logic               turn_ok;
  logic signed [17:0] factor;
  logic signed [33:0] prod_in;

  logic               f1_valid;
  op_t                f1_op;
  logic               f1_spin;
  logic signed [15:0] f1_turn;
  logic signed [15:0] f1_speed;
  logic signed [33:0] f1_prod;
  logic               f1_left_edge;
  logic               f1_right_edge;

  logic signed [16:0] turn_biased;
  logic signed [16:0] spin_goal;
  logic signed [16:0] spin_neg;
  logic signed [33:0] right_prod;
  logic               advance;

  assign turn_ok = (turn >= -16'sd16384) && (turn <= 16'sd16384);

  always_comb begin
    unique case (kind)
      KIND_CMD:     f1_op_in = turn_ok ? OP_CMD : OP_NOP;
      KIND_TICK:    f1_op_in = OP_TICK;
      KIND_TIMEOUT: f1_op_in = (drive_mode == MODE_AUTO) ? OP_CLEAR : OP_NOP;
      KIND_EDGE:    f1_op_in = OP_EDGE;
      KIND_SAMPLE:  f1_op_in = OP_SAMPLE;
      default:      f1_op_in = OP_NOP;
    endcase
  end

  // Left goal is speed*(1-turn); the right one is derived from the same product.
  assign factor  = 18'sd16384 - {{2{turn[15]}}, turn};
  assign prod_in = speed * factor;

  assign advance  = in_valid && in_ready;
  assign in_ready = !f1_valid || q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
    end else if (in_ready) begin
      f1_valid <= in_valid;
    end
    if (advance) begin
      f1_op         <= f1_op_in;
      f1_spin       <= (speed == 16'sd0);
      f1_turn       <= turn;
      f1_speed      <= speed;
      f1_prod       <= prod_in;
      f1_left_edge  <= left_edge;
      f1_right_edge <= right_edge;
    end
  end

  assign turn_biased = {f1_turn[15], f1_turn} + (f1_turn[15] ? TURN_BIAS : 17'd0);
  assign spin_goal   = turn_biased >>> TURN_SHIFT;
  assign spin_neg    = -spin_goal;
  assign right_prod  = $signed({{3{f1_speed[15]}}, f1_speed, 15'd0}) - f1_prod;

  always_comb begin
    q_entry.op         = f1_op;
    q_entry.left_edge  = f1_left_edge;
    q_entry.right_edge = f1_right_edge;
    if (f1_spin) begin
      q_entry.left_goal  = spin_goal[15:0];
      q_entry.right_goal = spin_neg[15:0];
    end else begin
      q_entry.left_goal  = div_q14_sat(f1_prod);
      q_entry.right_goal = div_q14_sat(right_prod);
    end
  end

  assign q_push = f1_valid && q_ready;

endmodule

// ----- sv/ddsr_queue.sv -----
module ddsr_queue #(
  parameter int DEPTH = ddsr_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  output logic                   push_ready,
  input  ddsr_pkg::queue_entry_t push_entry,
  output logic                   head_valid,
  input  logic                   pop,
  output ddsr_pkg::queue_entry_t head_entry
);
  import ddsr_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  queue_entry_t     mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             full;

  assign full       = (count == CNT_W'(DEPTH));
  assign push_ready = !full;
  assign head_valid = (count != '0);
  assign head_entry = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue written while full");
  assert property (@(posedge clk) disable iff (rst) pop |-> head_valid)
    else $error("queue read while empty");

endmodule

// ----- sv/ddsr_back.sv -----
module ddsr_back #(
  parameter int DEADBAND = ddsr_pkg::DEADBAND_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [ddsr_pkg::ACCEL_W-1:0] accel_step,
  input  logic                         q_valid,
  input  ddsr_pkg::queue_entry_t       q_entry,
  output logic                         q_pop,
  output logic                         rec_valid,
  output ddsr_pkg::ramp_rec_t          rec,
  input  logic                         rec_ready
);
  import ddsr_pkg::*;

  localparam logic signed [16:0] DB_POS = 17'(DEADBAND);
  localparam logic signed [16:0] DB_NEG = -DB_POS;

  function automatic logic signed [15:0] slew(input logic signed [15:0] cur,
                                              input logic signed [15:0] goal,
                                              input logic [ACCEL_W-1:0] step);
    logic signed [16:0] diff;
    logic signed [17:0] up;
    logic signed [17:0] down;
    logic signed [17:0] goal_x;
    diff   = $signed({goal[15], goal}) - $signed({cur[15], cur});
    up     = $signed({{2{cur[15]}}, cur}) + $signed({3'b000, step});
    down   = $signed({{2{cur[15]}}, cur}) - $signed({3'b000, step});
    goal_x = $signed({{2{goal[15]}}, goal});
    if (diff > DB_POS) begin
      return (up > goal_x) ? goal : up[15:0];
    end else if (diff < DB_NEG) begin
      return (down < goal_x) ? goal : down[15:0];
    end else begin
      return cur;
    end
  endfunction

  logic signed [15:0] left_goal;
  logic signed [15:0] right_goal;
  logic signed [15:0] left_velocity;
  logic signed [15:0] right_velocity;
  logic [15:0]        left_count;
  logic [15:0]        right_count;
  logic               left_fwd;
  logic               right_fwd;

  logic signed [15:0] left_next;
  logic signed [15:0] right_next;

  assign q_pop      = q_valid && (!rec_valid || rec_ready);
  assign left_next  = slew(left_velocity, left_goal, accel_step);
  assign right_next = slew(right_velocity, right_goal, accel_step);

  always_ff @(posedge clk) begin
    if (rst) begin
      left_goal      <= '0;
      right_goal     <= '0;
      left_velocity  <= '0;
      right_velocity <= '0;
      left_count     <= '0;
      right_count    <= '0;
      left_fwd       <= 1'b1;
      right_fwd      <= 1'b1;
      rec_valid      <= 1'b0;
    end else begin
      if (q_pop) begin
        rec_valid <= 1'b1;
      end else if (rec_ready) begin
        rec_valid <= 1'b0;
      end
      if (q_pop) begin
        unique case (q_entry.op)
          OP_CMD: begin
            left_goal  <= q_entry.left_goal;
            right_goal <= q_entry.right_goal;
          end
          OP_TICK: begin
            left_velocity  <= left_next;
            right_velocity <= right_next;
            left_fwd       <= !left_next[15];
            right_fwd      <= !right_next[15];
          end
          OP_CLEAR: begin
            left_goal  <= '0;
            right_goal <= '0;
          end
          OP_EDGE: begin
            if (q_entry.left_edge) begin
              left_count <= left_fwd ? left_count + 16'd1 : left_count - 16'd1;
            end
            if (q_entry.right_edge) begin
              right_count <= right_fwd ? right_count + 16'd1 : right_count - 16'd1;
            end
          end
          OP_SAMPLE: begin
            left_count  <= '0;
            right_count <= '0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // The record carries the velocities as they stand after this item.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      rec.left_write  <= (q_entry.op == OP_TICK) && (left_next != left_velocity);
      rec.right_write <= (q_entry.op == OP_TICK) && (right_next != right_velocity);
      rec.left_steps  <= (q_entry.op == OP_SAMPLE) ? left_count : '0;
      rec.right_steps <= (q_entry.op == OP_SAMPLE) ? right_count : '0;
      rec.left_speed  <= (q_entry.op == OP_TICK) ? left_next : left_velocity;
      rec.right_speed <= (q_entry.op == OP_TICK) ? right_next : right_velocity;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    rec_valid && !rec_ready |=> rec_valid && $stable(rec))
    else $error("pending ramp record lost or altered");

endmodule

// ----- sv/ddsr_out.sv -----
module ddsr_out #(
  parameter int VEL_FRAC_BITS = ddsr_pkg::VEL_FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [ddsr_pkg::GAIN_W-1:0] step_gain,
  input  logic                        rec_valid,
  input  ddsr_pkg::ramp_rec_t         rec,
  output logic                        rec_ready,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [19:0]                 left_freq,
  output logic [19:0]                 right_freq,
  output logic                        left_dir_level,
  output logic                        right_dir_level,
  output logic                        left_write,
  output logic                        right_write,
  output logic signed [15:0]          left_speed_now,
  output logic signed [15:0]          right_speed_now,
  output logic signed [15:0]          left_steps,
  output logic signed [15:0]          right_steps
);
  import ddsr_pkg::*;

  function automatic logic [FREQ_W-1:0] freq_of(input logic signed [15:0] v,
                                                input logic [GAIN_W-1:0] gain);
    logic [15:0] mag;
    logic [31:0] prod;
    logic [31:0] scaled;
    mag    = v[15] ? 16'(-v) : v;
    prod   = mag * gain;
    scaled = prod >> VEL_FRAC_BITS;
    return (scaled[31:FREQ_W] != '0) ? {FREQ_W{1'b1}} : scaled[FREQ_W-1:0];
  endfunction

  logic load;

  assign rec_ready = !out_valid || out_ready;
  assign load      = rec_valid && rec_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rec_ready) begin
      out_valid <= rec_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      left_freq       <= freq_of(rec.left_speed, step_gain);
      right_freq      <= freq_of(rec.right_speed, step_gain);
      left_dir_level  <= !rec.left_speed[15];
      right_dir_level <= rec.right_speed[15] || (rec.right_speed == 16'sd0);
      left_write      <= rec.left_write;
      right_write     <= rec.right_write;
      left_speed_now  <= rec.left_speed;
      right_speed_now <= rec.right_speed;
      left_steps      <= $signed(rec.left_steps);
      right_steps     <= $signed(rec.right_steps);
    end
  end

endmodule

// ----- sv/diff_drive_stepper_ramp.sv -----
// Velocity ramp for a two-wheel stepper drive.
// Input items (in_valid/in_ready) carry a kind: a speed and turn command, a
// control tick, a timeout, step edges, or a request to sample the step counts.
// Every accepted item gives exactly one result (out_valid/out_ready) with the
// step frequencies, direction levels and velocities of both wheels, write
// flags on a tick and the step counts on a sample.
// The front registers each item, classifies it and forms the wheel goals of a
// command with one multiplier; a four-entry queue then decouples it from the
// back, which holds the ramp state; the output stage forms the frequencies.
// Items pass the front register, the queue, the back and output registers;
// one item is taken every cycle while the receiver keeps out_ready high.
// When the receiver stalls, results wait in the output register, then in the
// back stage, the queue and the front register; in_ready falls only once all
// of these are full.
// Reset clears goals, velocities and counts, sets both count directions
// forward and loads the register defaults. The configuration port takes a
// write in any cycle and is meant to be written while no item is in flight.
module diff_drive_stepper_ramp #(
  parameter int VEL_FRAC_BITS = ddsr_pkg::VEL_FRAC_BITS_DEF,
  parameter int DEADBAND      = ddsr_pkg::DEADBAND_DEF,
  parameter int QUEUE_DEPTH   = ddsr_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [ddsr_pkg::IDX_W-1:0] cfg_index,
  input  logic [ddsr_pkg::CFG_W-1:0] cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [2:0]                 kind,
  input  logic signed [15:0]         speed,
  input  logic signed [15:0]         turn,
  input  logic                       left_edge,
  input  logic                       right_edge,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [19:0]                left_freq,
  output logic [19:0]                right_freq,
  output logic                       left_dir_level,
  output logic                       right_dir_level,
  output logic                       left_write,
  output logic                       right_write,
  output logic signed [15:0]         left_speed_now,
  output logic signed [15:0]         right_speed_now,
  output logic signed [15:0]         left_steps,
  output logic signed [15:0]         right_steps
);
  import ddsr_pkg::*;

  logic [ACCEL_W-1:0] accel_step;
  logic [GAIN_W-1:0]  step_gain;
  logic [MODE_W-1:0]  drive_mode;

  logic         q_push;
  logic         q_ready;
  queue_entry_t q_in;
  logic         head_valid;
  logic         q_pop;
  queue_entry_t head_entry;
  logic         rec_valid;
  logic         rec_ready;
  ramp_rec_t    rec;

  always_ff @(posedge clk) begin
    if (rst) begin
      accel_step <= ACCEL_RESET;
      step_gain  <= GAIN_RESET;
      drive_mode <= MODE_AUTO;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_ACCEL: accel_step <= cfg_data[ACCEL_W-1:0];
        CFG_GAIN:  step_gain  <= cfg_data[GAIN_W-1:0];
        CFG_MODE:  drive_mode <= cfg_data[MODE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  ddsr_front #(
    .VEL_FRAC_BITS(VEL_FRAC_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .drive_mode(drive_mode),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .kind      (kind),
    .speed     (speed),
    .turn      (turn),
    .left_edge (left_edge),
    .right_edge(right_edge),
    .q_push    (q_push),
    .q_ready   (q_ready),
    .q_entry   (q_in)
  );

  ddsr_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_ready(q_ready),
    .push_entry(q_in),
    .head_valid(head_valid),
    .pop       (q_pop),
    .head_entry(head_entry)
  );

  ddsr_back #(
    .DEADBAND(DEADBAND)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .accel_step(accel_step),
    .q_valid   (head_valid),
    .q_entry   (head_entry),
    .q_pop     (q_pop),
    .rec_valid (rec_valid),
    .rec       (rec),
    .rec_ready (rec_ready)
  );

  ddsr_out #(
    .VEL_FRAC_BITS(VEL_FRAC_BITS)
  ) u_out (
    .clk            (clk),
    .rst            (rst),
    .step_gain      (step_gain),
    .rec_valid      (rec_valid),
    .rec            (rec),
    .rec_ready      (rec_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .left_freq      (left_freq),
    .right_freq     (right_freq),
    .left_dir_level (left_dir_level),
    .right_dir_level(right_dir_level),
    .left_write     (left_write),
    .right_write    (right_write),
    .left_speed_now (left_speed_now),
    .right_speed_now(right_speed_now),
    .left_steps     (left_steps),
    .right_steps    (right_steps)
  );

endmodule

// ----- sim/diff_drive_stepper_ramp_test.sv -----
module diff_drive_stepper_ramp_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ddsr_pkg::*;

  localparam int CLK_PERIOD       = 10;
  localparam int RANDOM_PER_PHASE = 120;
  localparam int PHASE_COUNT      = 6;
  localparam int PRESSURE_PHASE   = 4;
  localparam int HOLD_CYCLES      = 64;
  localparam int SETTLE_CYCLES    = 8;
  localparam int CYCLE_LIMIT      = 200000;
  localparam int REPORT_LIMIT     = 10;
  localparam int FRAC             = VEL_FRAC_BITS_DEF;
  localparam int DEAD             = DEADBAND_DEF;
  localparam longint TURN_ONE     = 16384;

  localparam logic [2:0]        KIND_SPARE_FIRST = 3'd5;
  localparam logic [2:0]        KIND_SPARE_LAST  = 3'd7;
  localparam logic [IDX_W-1:0]  CFG_SPARE        = 2'd3;
  localparam logic [MODE_W-1:0] MODE_SPARE       = 2'd3;

  typedef struct packed {
    logic [FREQ_W-1:0]       left_freq;
    logic [FREQ_W-1:0]       right_freq;
    logic                    left_dir_level;
    logic                    right_dir_level;
    logic                    left_write;
    logic                    right_write;
    logic signed [VEL_W-1:0] left_speed_now;
    logic signed [VEL_W-1:0] right_speed_now;
    logic signed [VEL_W-1:0] left_steps;
    logic signed [VEL_W-1:0] right_steps;
  } ramp_result_t;

  typedef struct {
    logic [2:0]         kind;
    logic signed [15:0] speed;
    logic signed [15:0] turn;
    logic               left_edge;
    logic               right_edge;
    bit                 typed;
    ramp_result_t       want;
  } stim_row_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_write;
  logic [IDX_W-1:0]     cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  logic [2:0]           kind;
  logic signed [15:0]   speed;
  logic signed [15:0]   turn;
  logic                 left_edge;
  logic                 right_edge;
  logic                 out_valid;
  logic                 out_ready;
  logic [19:0]          left_freq;
  logic [19:0]          right_freq;
  logic                 left_dir_level;
  logic                 right_dir_level;
  logic                 left_write;
  logic                 right_write;
  logic signed [15:0]   left_speed_now;
  logic signed [15:0]   right_speed_now;
  logic signed [15:0]   left_steps;
  logic signed [15:0]   right_steps;

  // Shadow of the ramp state and registers.
  int                   goal_l, goal_r, vel_l, vel_r;
  logic [15:0]          cnt_l, cnt_r;
  logic                 fwd_l, fwd_r;
  logic [ACCEL_W-1:0]   cfg_accel;
  logic [GAIN_W-1:0]    cfg_gain;
  logic [MODE_W-1:0]    cfg_mode;

  ramp_result_t         ramp_expect[$];
  stim_row_t            directed_rows[$];
  bit                   row_typed;
  ramp_result_t         row_want;

  int send_gap_pct;
  int recv_gap_pct;
  int phase_no;
  int phase_items;
  bit hold_done;
  int fail_count;
  int report_count;
  int checked_count;
  int cycle_count;
  int stall_cycles;
  int moved_ticks;
  int counted_samples;

  diff_drive_stepper_ramp uut (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .kind            (kind),
    .speed           (speed),
    .turn            (turn),
    .left_edge       (left_edge),
    .right_edge      (right_edge),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .left_freq       (left_freq),
    .right_freq      (right_freq),
    .left_dir_level  (left_dir_level),
    .right_dir_level (right_dir_level),
    .left_write      (left_write),
    .right_write     (right_write),
    .left_speed_now  (left_speed_now),
    .right_speed_now (right_speed_now),
    .left_steps      (left_steps),
    .right_steps     (right_steps)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic int clamp_vel(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return int'(v);
  endfunction

  // Moves one wheel towards its goal, leaving it alone inside the deadband.
  function automatic int step_toward(int cur, int goal);
    int diff;
    diff = goal - cur;
    if (diff > DEAD) begin
      cur = cur + int'(cfg_accel);
      if (cur > goal) cur = goal;
    end else if (diff < -DEAD) begin
      cur = cur - int'(cfg_accel);
      if (cur < goal) cur = goal;
    end
    return cur;
  endfunction

  function automatic logic [FREQ_W-1:0] freq_of(int v);
    longint mag;
    longint f;
    mag = (v < 0) ? -longint'(v) : longint'(v);
    f = (mag * longint'(cfg_gain)) >> FRAC;
    return (f > 64'hFFFFF) ? 20'hFFFFF : f[FREQ_W-1:0];
  endfunction

  // Result of an item while both wheels stand still, with the given step counts.
  function automatic ramp_result_t at_rest(logic signed [15:0] ls, logic signed [15:0] rs);
    ramp_result_t r;
    r = '0;
    r.left_dir_level = 1'b1;
    r.right_dir_level = 1'b1;
    r.left_steps = ls;
    r.right_steps = rs;
    return r;
  endfunction

  task automatic predict_item(input logic [2:0] k, input logic signed [15:0] spd,
                              input logic signed [15:0] trn, input logic le,
                              input logic re, output ramp_result_t r);
    longint t;
    int nl, nr;
    r = '0;
    case (k)
      KIND_CMD: begin
        if (trn >= -16384 && trn <= 16384) begin
          if (spd == 0) begin
            t = (longint'(trn) * (longint'(1) << FRAC)) / TURN_ONE;
            goal_l = clamp_vel(t);
            goal_r = clamp_vel(-t);
          end else begin
            goal_l = clamp_vel((longint'(spd) * (TURN_ONE - longint'(trn))) / TURN_ONE);
            goal_r = clamp_vel((longint'(spd) * (TURN_ONE + longint'(trn))) / TURN_ONE);
          end
        end
      end
      KIND_TICK: begin
        nl = step_toward(vel_l, goal_l);
        nr = step_toward(vel_r, goal_r);
        r.left_write = (nl != vel_l);
        r.right_write = (nr != vel_r);
        if (r.left_write || r.right_write) moved_ticks++;
        vel_l = nl;
        vel_r = nr;
        fwd_l = (vel_l >= 0);
        fwd_r = (vel_r >= 0);
      end
      KIND_TIMEOUT: begin
        if (cfg_mode == MODE_AUTO) begin
          goal_l = 0;
          goal_r = 0;
        end
      end
      KIND_EDGE: begin
        if (le) cnt_l = cnt_l + (fwd_l ? 16'h0001 : 16'hFFFF);
        if (re) cnt_r = cnt_r + (fwd_r ? 16'h0001 : 16'hFFFF);
      end
      KIND_SAMPLE: begin
        r.left_steps = cnt_l;
        r.right_steps = cnt_r;
        if (cnt_l != 0 || cnt_r != 0) counted_samples++;
        cnt_l = '0;
        cnt_r = '0;
      end
      default: ;
    endcase
    r.left_freq = freq_of(vel_l);
    r.right_freq = freq_of(vel_r);
    r.left_dir_level = (vel_l >= 0);
    r.right_dir_level = !(vel_r > 0);
    r.left_speed_now = vel_l[15:0];
    r.right_speed_now = vel_r[15:0];
  endtask

  task automatic add_row(input logic [2:0] k, input logic signed [15:0] spd,
                         input logic signed [15:0] trn, input logic le, input logic re,
                         input bit typed = 0, input ramp_result_t want = '0);
    stim_row_t row;
    row.kind = k;
    row.speed = spd;
    row.turn = trn;
    row.left_edge = le;
    row.right_edge = re;
    row.typed = typed;
    row.want = want;
    directed_rows.push_back(row);
  endtask

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_item(input logic [2:0] k, input logic signed [15:0] spd,
                           input logic signed [15:0] trn, input logic le, input logic re,
                           input bit typed, input ramp_result_t want);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    kind = k;
    speed = spd;
    turn = trn;
    left_edge = le;
    right_edge = re;
    row_typed = typed;
    row_want = want;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    case (idx)
      CFG_ACCEL: cfg_accel = data[ACCEL_W-1:0];
      CFG_GAIN:  cfg_gain = data[GAIN_W-1:0];
      CFG_MODE:  cfg_mode = data[MODE_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  task automatic wait_idle();
    in_valid = 1'b0;
    while (ramp_expect.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Mostly ramps: commands followed by plenty of ticks, with edges and samples
  // in between, plus the odd timeout and unused kind.
  task automatic random_item(output logic [2:0] k, output logic signed [15:0] spd,
                             output logic signed [15:0] trn, output logic le,
                             output logic re);
    int pick;
    int sel;
    spd = 16'($urandom);
    trn = 16'($urandom);
    le = 1'($urandom_range(1));
    re = 1'($urandom_range(1));
    pick = $urandom_range(99);
    if (pick < 15) begin
      k = KIND_CMD;
      sel = $urandom_range(9);
      if (sel < 4) spd = 16'($urandom_range(4000) - 2000);
      else if (sel == 4) spd = '0;
      else if (sel == 5) spd = $urandom_range(1) ? 16'sd32767 : -16'sd32768;
      sel = $urandom_range(9);
      if (sel < 7) trn = 16'($urandom_range(32768) - 16384);
      else if (sel == 7) begin
        case ($urandom_range(2))
          0: trn = 16'sd16384;
          1: trn = -16'sd16384;
          default: trn = '0;
        endcase
      end
    end else if (pick < 55) k = KIND_TICK;
    else if (pick < 60) k = KIND_TIMEOUT;
    else if (pick < 82) k = KIND_EDGE;
    else if (pick < 92) k = KIND_SAMPLE;
    else k = 3'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST));
  endtask

  always @(posedge clk) begin : monitor
    ramp_result_t pred;
    ramp_result_t want;
    ramp_result_t got;
    if (!rst) begin
      if (in_valid && in_ready) begin
        predict_item(kind, speed, turn, left_edge, right_edge, pred);
        ramp_expect.push_back(row_typed ? row_want : pred);
      end
      if (in_valid && !in_ready) stall_cycles++;
      if (out_valid && out_ready) begin
        got = '{left_freq, right_freq, left_dir_level, right_dir_level, left_write,
                right_write, left_speed_now, right_speed_now, left_steps, right_steps};
        if (ramp_expect.size() == 0) begin
          fail_count++;
          if (report_count < REPORT_LIMIT) begin
            report_count++;
            $display("unexpected result transfer at cycle %0d", cycle_count);
          end
        end else begin
          want = ramp_expect.pop_front();
          checked_count++;
          if (got !== want) begin
            fail_count++;
            if (report_count < REPORT_LIMIT) begin
              report_count++;
              $display("result %0d wrong: want freq %0d/%0d dir %0b/%0b wr %0b/%0b",
                       checked_count, want.left_freq, want.right_freq,
                       want.left_dir_level, want.right_dir_level,
                       want.left_write, want.right_write);
              $display("  want vel %0d/%0d steps %0d/%0d", want.left_speed_now,
                       want.right_speed_now, want.left_steps, want.right_steps);
              $display("  got freq %0d/%0d dir %0b/%0b wr %0b/%0b vel %0d/%0d steps %0d/%0d",
                       got.left_freq, got.right_freq, got.left_dir_level,
                       got.right_dir_level, got.left_write, got.right_write,
                       got.left_speed_now, got.right_speed_now,
                       got.left_steps, got.right_steps);
            end
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timed out after %0d cycles", cycle_count);
      $display("TB_ERROR");
      $finish;
    end
  end

  // Receiver. During the pressure phase it holds off for a long stretch while
  // the sender keeps offering, so that the queue fills and in_ready falls.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (phase_no == PRESSURE_PHASE && !hold_done && phase_items >= 10) begin
        hold_done = 1'b1;
        out_ready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        out_ready = ($urandom_range(99) >= recv_gap_pct);
      end
    end
  end

  initial begin
    logic [2:0]         k;
    logic signed [15:0] spd;
    logic signed [15:0] trn;
    logic               le;
    logic               re;
    clk = 1'b0;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = CFG_ACCEL;
    cfg_data = '0;
    in_valid = 1'b0;
    kind = KIND_CMD;
    speed = '0;
    turn = '0;
    left_edge = 1'b0;
    right_edge = 1'b0;
    row_typed = 1'b0;
    row_want = '0;
    phase_no = -1;
    send_gap_pct = 18;
    recv_gap_pct = 55;

    cfg_accel = ACCEL_RESET;
    cfg_gain = GAIN_RESET;
    cfg_mode = MODE_AUTO;
    goal_l = 0;
    goal_r = 0;
    vel_l = 0;
    vel_r = 0;
    cnt_l = '0;
    cnt_r = '0;
    fwd_l = 1'b1;
    fwd_r = 1'b1;

    add_row(KIND_SAMPLE, 0, 0, 0, 0, 1, at_rest(0, 0));
    add_row(KIND_TICK, 0, 0, 0, 0, 1, at_rest(0, 0));
    add_row(KIND_EDGE, 0, 0, 1, 1, 1, at_rest(0, 0));
    add_row(KIND_EDGE, 0, 0, 1, 0, 1, at_rest(0, 0));
    add_row(KIND_SAMPLE, 0, 0, 0, 0, 1, at_rest(2, 1));
    add_row(KIND_EDGE, 0, 0, 1, 1);
    // A goal inside the deadband leaves the wheels at rest.
    add_row(KIND_CMD, 3, 0, 0, 0);
    add_row(KIND_TICK, 0, 0, 0, 0, 1, at_rest(0, 0));
    // A tiny spin truncates to a zero goal.
    add_row(KIND_CMD, 0, -1, 0, 0, 1, at_rest(0, 0));
    add_row(KIND_CMD, 0, 16384, 0, 0);
    add_row(KIND_TICK, 0, 0, 0, 0);
    // The right wheel now runs backwards, so its count goes down and wraps.
    add_row(KIND_EDGE, 0, 0, 1, 1);
    add_row(KIND_SAMPLE, 0, 0, 0, 0);
    add_row(KIND_EDGE, 0, 0, 0, 1);
    add_row(KIND_SAMPLE, 0, 0, 0, 0);
    add_row(KIND_CMD, 32767, 0, 0, 0);
    add_row(KIND_TICK, 0, 0, 0, 0);
    add_row(KIND_CMD, -32768, -16384, 0, 0);
    add_row(KIND_CMD, 32767, 16384, 0, 0);
    add_row(KIND_CMD, 100, 16385, 0, 0);
    add_row(KIND_CMD, -1, -32768, 0, 0);
    add_row(KIND_TICK, 0, 0, 0, 0);
    add_row(KIND_TIMEOUT, 0, 0, 0, 0);
    add_row(KIND_TICK, 0, 0, 0, 0);
    add_row(KIND_SPARE_FIRST, -1, -1, 1, 1);
    add_row(KIND_SPARE_LAST, 32767, -32768, 1, 1);

    repeat (2) @(negedge clk);
    rst = 1'b0;

    foreach (directed_rows[i])
      send_item(directed_rows[i].kind, directed_rows[i].speed, directed_rows[i].turn,
                directed_rows[i].left_edge, directed_rows[i].right_edge,
                directed_rows[i].typed, directed_rows[i].want);

    for (int p = 0; p < PHASE_COUNT; p++) begin
      wait_idle();
      case (p)
        0: begin
          write_reg(CFG_ACCEL, 16'd32767);
          write_reg(CFG_GAIN, 16'd65535);
          write_reg(CFG_MODE, CFG_W'(MODE_CONTINUOUS));
        end
        1: begin
          write_reg(CFG_ACCEL, 16'd0);
          write_reg(CFG_GAIN, 16'd0);
          write_reg(CFG_MODE, CFG_W'(MODE_TURN360));
        end
        2: begin
          write_reg(CFG_ACCEL, CFG_W'($urandom_range(600, 1)));
          write_reg(CFG_GAIN, CFG_W'($urandom_range(65535)));
          write_reg(CFG_MODE, CFG_W'(MODE_AUTO));
          write_reg(CFG_SPARE, CFG_W'($urandom_range(65535)));
        end
        3: begin
          write_reg(CFG_ACCEL, CFG_W'($urandom_range(2000, 1)));
          write_reg(CFG_GAIN, GAIN_RESET);
          write_reg(CFG_MODE, CFG_W'(MODE_SPARE));
        end
        4: begin
          write_reg(CFG_ACCEL, CFG_W'(ACCEL_RESET));
          write_reg(CFG_GAIN, CFG_W'($urandom_range(65535)));
          write_reg(CFG_MODE, CFG_W'(MODE_AUTO));
        end
        default: begin
          write_reg(CFG_ACCEL, CFG_W'($urandom_range(65535)));
          write_reg(CFG_GAIN, CFG_W'($urandom_range(65535)));
          write_reg(CFG_MODE, CFG_W'(MODE_CONTINUOUS));
        end
      endcase
      if (p < 2) begin
        send_gap_pct = 18;
        recv_gap_pct = 55;
      end else if (p < 4) begin
        send_gap_pct = 55;
        recv_gap_pct = 18;
      end else begin
        send_gap_pct = 0;
        recv_gap_pct = 0;
      end
      phase_items = 0;
      phase_no = p;
      while (phase_items < RANDOM_PER_PHASE) begin
        random_item(k, spd, trn, le, re);
        send_item(k, spd, trn, le, re, 1'b0, '0);
        phase_items++;
      end
    end

    wait_idle();
    fail_count += ramp_expect.size();
    $display("checked %0d results: %0d directed rows, %0d random phases over all drive modes",
             checked_count, directed_rows.size(), PHASE_COUNT);
    $display("%0d ticks moved a wheel, %0d samples held counts, input stalled %0d cycles",
             moved_ticks, counted_samples, stall_cycles);
    if (fail_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/ddsr_pkg.sv
sv/ddsr_front.sv
sv/ddsr_queue.sv
sv/ddsr_back.sv
sv/ddsr_out.sv
sv/diff_drive_stepper_ramp.sv
sim/diff_drive_stepper_ramp_test.sv
